// ----- design/gasp_pkg.sv -----
// ---------------------------------------------------------------------------
// Glyph atlas shelf packer package
// Shared widths, register codes, state and result types, and pen saturation and atlas size helpers.
// ---------------------------------------------------------------------------
package gasp_pkg;

	localparam int ID_W        = 16;
	localparam int DIM_W       = 10;
	localparam int PAD_W       = 4;
	localparam int FONT_W      = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int COORD_W     = 13;
	localparam int PEN_W       = 14;
	localparam int ATLAS_H_W   = 15;
	localparam int CALC_W      = 16;
	localparam int STEP_LOG2   = 8;

	localparam int DEFAULT_MAX_ATLAS_HEIGHT = 4096;

	localparam logic [CALC_W-1:0] PEN_MAX   = CALC_W'(16383);
	localparam logic [CALC_W-1:0] STEP_MASK = CALC_W'((1 << STEP_LOG2) - 1);

	localparam logic [PAD_W-1:0]  PADDING_RESET   = PAD_W'(1);
	localparam logic [FONT_W-1:0] FONT_SIZE_RESET = FONT_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PADDING   = 2'd0,
		CFG_FONT_SIZE = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                 allocated;
		logic [COORD_W-1:0]   atlas_w;
		logic [ATLAS_H_W-1:0] atlas_h;
		logic [PEN_W-1:0]     pen_x;
		logic [PEN_W-1:0]     pen_y;
		logic [DIM_W-1:0]     row_height;
	} pack_state_t;

	typedef struct packed {
		logic [ID_W-1:0]    placed_id;
		logic               accepted;
		logic [COORD_W-1:0] region_left;
		logic [COORD_W-1:0] region_top;
		logic [DIM_W-1:0]   region_width;
		logic [DIM_W-1:0]   region_height;
		logic [COORD_W-1:0] atlas_width;
		logic [COORD_W-1:0] atlas_height;
	} result_t;

	function automatic logic [PEN_W-1:0] sat_pen(input logic [CALC_W-1:0] v);
		return (v > PEN_MAX) ? PEN_MAX[PEN_W-1:0] : v[PEN_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] initial_width(input logic [FONT_W-1:0] fs);
		logic [COORD_W-1:0] w;
		if (fs <= FONT_W'(16))       w = COORD_W'(512);
		else if (fs <= FONT_W'(32))  w = COORD_W'(768);
		else if (fs <= FONT_W'(48))  w = COORD_W'(1024);
		else if (fs <= FONT_W'(64))  w = COORD_W'(1536);
		else if (fs <= FONT_W'(256)) w = COORD_W'(2048);
		else                         w = COORD_W'(4096);
		return w;
	endfunction

	function automatic logic [ATLAS_H_W-1:0] initial_height(input logic [FONT_W-1:0] fs);
		return (fs <= FONT_W'(256)) ? ATLAS_H_W'(256) : ATLAS_H_W'(512);
	endfunction

endpackage

// ----- design/glyph_atlas_shelf_packer_top.sv -----
// ---------------------------------------------------------------------------
// Glyph atlas shelf packer
// Places glyph rectangles into a texture atlas row by row.
// ---------------------------------------------------------------------------
// The block takes one glyph word per clock when not stalled and returns
// one result per glyph in the next cycle; throughput is set by the
// combinational path from the pen state registers through the wrap, height
// growth and advance logic back into those registers. The result register
// lets a new glyph enter in the same cycle as the waiting result is taken.
// The first glyph after reset sizes the atlas from font_base_size; a glyph
// that would need an atlas taller than MAX_ATLAS_HEIGHT is refused with a
// zero region, but its pen moves are kept. No clearing pass follows reset.
module glyph_atlas_shelf_packer_top import gasp_pkg::*; #(
	parameter int MAX_ATLAS_HEIGHT = DEFAULT_MAX_ATLAS_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  glyph_valid,
	output logic                  glyph_stall,
	input  logic [ID_W-1:0]       glyph_id,
	input  logic [DIM_W-1:0]      glyph_width,
	input  logic [DIM_W-1:0]      glyph_height,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [ID_W-1:0]       placed_id,
	output logic                  accepted,
	output logic [COORD_W-1:0]    region_left,
	output logic [COORD_W-1:0]    region_top,
	output logic [DIM_W-1:0]      region_width,
	output logic [DIM_W-1:0]      region_height,
	output logic [COORD_W-1:0]    atlas_width,
	output logic [COORD_W-1:0]    atlas_height
);

	logic [PAD_W-1:0]  padding_q;
	logic [FONT_W-1:0] font_size_q;
	pack_state_t       state_q;
	pack_state_t       state_nxt;
	result_t           res;
	result_t           out_word;
	logic              busy;
	logic              take;

	assign cfg_ready   = 1'b1;
	assign glyph_stall = busy;
	assign take        = glyph_valid & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			padding_q   <= PADDING_RESET;
			font_size_q <= FONT_SIZE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PADDING:   padding_q   <= cfg_data[PAD_W-1:0];
				CFG_FONT_SIZE: font_size_q <= cfg_data[FONT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	gasp_place #(
		.MAX_ATLAS_HEIGHT(MAX_ATLAS_HEIGHT)
	) u_place (
		.cur            (state_q),
		.padding        (padding_q),
		.font_base_size (font_size_q),
		.glyph_id       (glyph_id),
		.glyph_width    (glyph_width),
		.glyph_height   (glyph_height),
		.nxt            (state_nxt),
		.res            (res)
	);

	gasp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.load_word (res),
		.stall     (result_stall),
		.busy      (busy),
		.valid     (result_valid),
		.word      (out_word)
	);

	assign placed_id     = out_word.placed_id;
	assign accepted      = out_word.accepted;
	assign region_left   = out_word.region_left;
	assign region_top    = out_word.region_top;
	assign region_width  = out_word.region_width;
	assign region_height = out_word.region_height;
	assign atlas_width   = out_word.atlas_width;
	assign atlas_height  = out_word.atlas_height;

	// Every glyph taken shows up as a result word in the next cycle.
	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> result_valid)
		else $error("glyph taken but no result word followed");

	// Once any glyph has been taken the atlas stays allocated.
	a_alloc_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q.allocated)
		else $error("atlas not allocated after a glyph");

	// The atlas never grows past the height limit.
	a_height_limit: assert property (@(posedge clk) disable iff (!arst_n)
		CALC_W'(state_q.atlas_h) <= CALC_W'(MAX_ATLAS_HEIGHT))
		else $error("atlas height above limit");

	// A refused glyph carries an empty region.
	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !accepted) |->
			(region_left == '0 && region_top == '0 &&
			 region_width == '0 && region_height == '0))
		else $error("refused glyph reports a region");

endmodule

// ----- design/gasp_place.sv -----
// ---------------------------------------------------------------------------
// Shelf placement step
// Works out one glyph's region and the next pen and atlas state.
// ---------------------------------------------------------------------------
module gasp_place import gasp_pkg::*; #(
	parameter int MAX_ATLAS_HEIGHT = DEFAULT_MAX_ATLAS_HEIGHT
) (
	input  pack_state_t       cur,
	input  logic [PAD_W-1:0]  padding,
	input  logic [FONT_W-1:0] font_base_size,
	input  logic [ID_W-1:0]   glyph_id,
	input  logic [DIM_W-1:0]  glyph_width,
	input  logic [DIM_W-1:0]  glyph_height,
	output pack_state_t       nxt,
	output result_t           res
);

	localparam logic [CALC_W-1:0] MAX_H = CALC_W'(MAX_ATLAS_HEIGHT);

	always_comb begin
		logic [CALC_W-1:0]    pad;
		logic [CALC_W-1:0]    gw;
		logic [CALC_W-1:0]    gh;
		logic [COORD_W-1:0]   aw;
		logic [ATLAS_H_W-1:0] ah;
		logic [PEN_W-1:0]     px;
		logic [PEN_W-1:0]     py;
		logic [DIM_W-1:0]     rh;
		logic [CALC_W-1:0]    need;
		logic [CALC_W-1:0]    grown;
		logic                 ok;

		pad = CALC_W'(padding);
		gw  = CALC_W'(glyph_width);
		gh  = CALC_W'(glyph_height);

		// The first glyph after reset sizes the atlas from the font size.
		aw = cur.allocated ? cur.atlas_w : initial_width(font_base_size);
		ah = cur.allocated ? cur.atlas_h : initial_height(font_base_size);

		px = sat_pen(CALC_W'(cur.pen_x) + pad);
		py = cur.pen_y;
		rh = cur.row_height;

		// Wrap to a new shelf when the glyph and its gap pass the right edge.
		if (CALC_W'(aw) < CALC_W'(px) + gw + pad) begin
			px = PEN_W'(padding);
			py = sat_pen(CALC_W'(cur.pen_y) + CALC_W'(cur.row_height) + (pad << 1));
			rh = '0;
		end

		need  = CALC_W'(py) + gh + pad;
		grown = (need + STEP_MASK) & ~STEP_MASK;
		ok    = 1'b1;
		if (CALC_W'(ah) < need) begin
			if (MAX_H < grown) ok = 1'b0;
			else ah = grown[ATLAS_H_W-1:0];
		end

		res.placed_id    = glyph_id;
		res.accepted     = ok;
		res.atlas_width  = aw;
		res.atlas_height = ah[COORD_W-1:0];
		if (ok) begin
			res.region_left   = px[COORD_W-1:0];
			res.region_top    = py[COORD_W-1:0];
			res.region_width  = glyph_width;
			res.region_height = glyph_height;
			if (glyph_height > rh) rh = glyph_height;
			px = sat_pen(CALC_W'(px) + gw + pad);
		end else begin
			res.region_left   = '0;
			res.region_top    = '0;
			res.region_width  = '0;
			res.region_height = '0;
		end

		nxt.allocated  = 1'b1;
		nxt.atlas_w    = aw;
		nxt.atlas_h    = ah;
		nxt.pen_x      = px;
		nxt.pen_y      = py;
		nxt.row_height = rh;
	end

endmodule

// ----- design/gasp_out_reg.sv -----
// ---------------------------------------------------------------------------
// Result register
// Holds one result word until the downstream side takes it.
// ---------------------------------------------------------------------------
module gasp_out_reg import gasp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_word,
	input  logic    stall,
	output logic    busy,
	output logic    valid,
	output result_t word
);

	logic    valid_q;
	result_t word_q;

	// A new word may enter when the register is empty or is being drained.
	assign busy  = valid_q & stall;
	assign valid = valid_q;
	assign word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end
	end

endmodule

// ----- dv/glyph_atlas_shelf_packer_top_test.sv -----
// ---------------------------------------------------------------------------
// Glyph atlas shelf packer testbench
// Sizes the atlas from a font step, then packs directed and random glyphs
// through shelf wraps, height growth and refusals while both channels stall.
// Every result word is checked against an in-bench shelf placement model.
// ---------------------------------------------------------------------------
module glyph_atlas_shelf_packer_top_test;
	import gasp_pkg::*;

	localparam int          MAX_H           = DEFAULT_MAX_ATLAS_HEIGHT;
	localparam int unsigned PEN_LIMIT       = 16383;
	localparam int          STALL_PCT       = 21;
	localparam int          WATCHDOG_CYCLES = 1000;
	localparam int          SHOWN_FAILS     = 10;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  glyph_valid  = 1'b0;
	logic                  glyph_stall;
	logic [ID_W-1:0]       glyph_id     = '0;
	logic [DIM_W-1:0]      glyph_width  = '0;
	logic [DIM_W-1:0]      glyph_height = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [ID_W-1:0]       placed_id;
	logic                  accepted;
	logic [COORD_W-1:0]    region_left;
	logic [COORD_W-1:0]    region_top;
	logic [DIM_W-1:0]      region_width;
	logic [DIM_W-1:0]      region_height;
	logic [COORD_W-1:0]    atlas_width;
	logic [COORD_W-1:0]    atlas_height;

	// Shelf state as the block should hold it.
	bit                atlas_ready = 1'b0;
	int unsigned       atlas_w_px  = 0;
	int unsigned       atlas_h_px  = 0;
	int unsigned       pen_x_px    = 0;
	int unsigned       pen_y_px    = 0;
	int unsigned       shelf_h_px  = 0;
	logic [PAD_W-1:0]  gap_px      = PADDING_RESET;
	logic [FONT_W-1:0] font_sz     = FONT_SIZE_RESET;

	result_t placements_due[$];
	int      fail_count  = 0;
	int      idle_cycles = 0;
	bit      quiet       = 1'b0;

	int unsigned font_steps[14] = '{0, 1, 16, 17, 32, 33, 48, 49, 64, 65, 256, 257, 1024, 2047};

	glyph_atlas_shelf_packer_top #(
		.MAX_ATLAS_HEIGHT(MAX_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.glyph_valid(glyph_valid),
		.glyph_stall(glyph_stall),
		.glyph_id(glyph_id),
		.glyph_width(glyph_width),
		.glyph_height(glyph_height),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.placed_id(placed_id),
		.accepted(accepted),
		.region_left(region_left),
		.region_top(region_top),
		.region_width(region_width),
		.region_height(region_height),
		.atlas_width(atlas_width),
		.atlas_height(atlas_height)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned pen_clip(input int unsigned v);
		return (v > PEN_LIMIT) ? PEN_LIMIT : v;
	endfunction

	function automatic result_t place_glyph(input logic [ID_W-1:0] id,
			input logic [DIM_W-1:0] gw, input logic [DIM_W-1:0] gh);
		result_t     r;
		int unsigned need;
		int unsigned grown;
		bit          fits;
		if (!atlas_ready) begin
			if (font_sz <= 16) atlas_w_px = 512;
			else if (font_sz <= 32) atlas_w_px = 768;
			else if (font_sz <= 48) atlas_w_px = 1024;
			else if (font_sz <= 64) atlas_w_px = 1536;
			else if (font_sz <= 256) atlas_w_px = 2048;
			else atlas_w_px = 4096;
			atlas_h_px = (font_sz <= 256) ? 256 : 512;
			atlas_ready = 1'b1;
		end
		pen_x_px = pen_clip(pen_x_px + gap_px);
		// A glyph that overruns the right edge opens a new shelf below the current one.
		if (atlas_w_px < pen_x_px + gw + gap_px) begin
			pen_x_px = gap_px;
			pen_y_px = pen_clip(pen_y_px + shelf_h_px + 2 * gap_px);
			shelf_h_px = 0;
		end
		need = pen_y_px + gh + gap_px;
		fits = 1'b1;
		if (atlas_h_px < need) begin
			grown = (need + 255) / 256 * 256;
			if (grown > MAX_H) fits = 1'b0;
			else atlas_h_px = grown;
		end
		r = '0;
		r.placed_id = id;
		r.accepted = fits;
		if (fits) begin
			r.region_left = COORD_W'(pen_x_px);
			r.region_top = COORD_W'(pen_y_px);
			r.region_width = gw;
			r.region_height = gh;
			if (gh > shelf_h_px) shelf_h_px = gh;
			pen_x_px = pen_clip(pen_x_px + gw + gap_px);
		end
		r.atlas_width = COORD_W'(atlas_w_px);
		r.atlas_height = COORD_W'(atlas_h_px);
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("id %04h ok %0d at %0d,%0d size %0dx%0d atlas %0dx%0d",
			r.placed_id, r.accepted, r.region_left, r.region_top,
			r.region_width, r.region_height, r.atlas_width, r.atlas_height);
	endfunction

	// Mostly small sizes, with a tail that reaches the full field range.
	function automatic logic [DIM_W-1:0] pick_dim(input int small_pct, input int mid_pct,
			input int mid_top);
		int roll;
		roll = $urandom_range(99);
		if (roll < small_pct) return DIM_W'($urandom_range(31));
		if (roll < small_pct + mid_pct) return DIM_W'($urandom_range(mid_top, 32));
		return DIM_W'($urandom_range(1023, mid_top + 1));
	endfunction

	// Checks result words first, so a word leaving this edge never meets one entering it.
	always @(posedge clk) begin : scoreboard
		result_t want;
		result_t got;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got.placed_id = placed_id;
				got.accepted = accepted;
				got.region_left = region_left;
				got.region_top = region_top;
				got.region_width = region_width;
				got.region_height = region_height;
				got.atlas_width = atlas_width;
				got.atlas_height = atlas_height;
				if (placements_due.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOWN_FAILS)
						$display("unexpected result word: %s", describe(got));
				end else begin
					want = placements_due.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= SHOWN_FAILS)
							$display("placement mismatch\n  expected %s\n  actual   %s",
								describe(want), describe(got));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PADDING: gap_px = cfg_data[PAD_W-1:0];
					CFG_FONT_SIZE: font_sz = cfg_data[FONT_W-1:0];
					default: ;
				endcase
			end
			if (glyph_valid && !glyph_stall)
				placements_due.push_back(place_glyph(glyph_id, glyph_width, glyph_height));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((glyph_valid && !glyph_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("no word moved for %0d cycles", idle_cycles);
				$display("glyph_atlas_shelf_packer_top_test failed");
				$finish;
			end
		end
	end

	always @(negedge clk)
		result_stall <= !quiet && ($urandom_range(99) < STALL_PCT);

	task automatic send_glyph(input logic [ID_W-1:0] id, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < STALL_PCT) begin
			glyph_valid <= 1'b0;
			@(negedge clk);
		end
		glyph_valid <= 1'b1;
		glyph_id <= id;
		glyph_width <= w;
		glyph_height <= h;
		do @(posedge clk); while (glyph_stall);
	endtask

	task automatic settle();
		@(negedge clk);
		glyph_valid <= 1'b0;
		while (placements_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_atlas_sizing();
		write_reg(CFG_FONT_SIZE, CFG_DATA_W'(font_steps[$urandom_range(13)]));
		write_reg(CFG_SPARE_A, 11'h7FF);
		write_reg(CFG_SPARE_B, 11'h000);
		// The first glyph sizes the atlas; the reset gap of one pixel is still in force.
		send_glyph(16'h0000, 10'd0, 10'd0);
		send_glyph(16'hFFFF, 10'd1023, 10'd1);
		send_glyph(16'h5555, 10'd1, 10'd1023);
	endtask

	task automatic check_padding_extremes();
		int n;
		settle();
		// Upper data bits are set but only the low four belong to the gap.
		write_reg(CFG_PADDING, 11'h7F0);
		send_glyph(16'hAAAA, 10'h155, 10'h2AA);
		send_glyph(16'h1234, 10'h2AA, 10'h155);
		for (n = 0; n < 5; n++) send_glyph(ID_W'(16'h0100 + n), 10'd300, 10'd20);
		settle();
		write_reg(CFG_PADDING, 11'h00F);
		send_glyph(16'h0001, 10'd0, 10'd0);
		send_glyph(16'h0002, 10'd1023, 10'd0);
		for (n = 0; n < 4; n++) send_glyph(ID_W'(16'h0200 + n), 10'd200, 10'd40);
	endtask

	task automatic check_random_shelves();
		int               phase;
		int               n;
		logic [PAD_W-1:0] gap;
		for (phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: gap = PAD_W'($urandom_range(14, 1));
				1: gap = '0;
				2: gap = '1;
				default: gap = PAD_W'($urandom_range(15));
			endcase
			write_reg(CFG_PADDING, {(CFG_DATA_W - PAD_W)'($urandom), gap});
			// The atlas is sized already, so a new font size must not move it.
			write_reg(CFG_FONT_SIZE, CFG_DATA_W'($urandom));
			quiet = (phase == 1);
			for (n = 0; n < 60; n++)
				send_glyph(ID_W'($urandom), pick_dim(80, 15, 255), pick_dim(85, 13, 127));
		end
		quiet = 1'b0;
	endtask

	task automatic check_atlas_exhaustion();
		int               n;
		int               topped;
		logic [DIM_W-1:0] gw;
		settle();
		write_reg(CFG_PADDING, {(CFG_DATA_W - PAD_W)'($urandom), 4'hF});
		for (n = 0; n < 8; n++)
			send_glyph(ID_W'($urandom), DIM_W'($urandom_range(1023)),
				DIM_W'($urandom_range(1023, 768)));
		// Refused glyphs keep their wraps, so a run of full-width refusals walks the
		// pen down until it saturates. Wide atlases never wrap this way.
		topped = 0;
		for (n = 0; n < 480 && topped < 16; n++) begin
			if (pen_y_px == PEN_LIMIT) topped++;
			if (atlas_w_px > 1024 && n >= 380) break;
			if (atlas_w_px <= 1024) gw = DIM_W'($urandom_range(1023, atlas_w_px - 44));
			else gw = DIM_W'($urandom_range(1023));
			send_glyph(ID_W'($urandom), gw, DIM_W'($urandom_range(1023)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_atlas_sizing();
		check_padding_extremes();
		check_random_shelves();
		check_atlas_exhaustion();
		settle();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && placements_due.size() == 0)
			$display("glyph_atlas_shelf_packer_top_test passed");
		else
			$display("glyph_atlas_shelf_packer_top_test failed");
		$finish;
	end

endmodule
